// ----- design/rtt_pkg.sv -----
// Shared constants, codes and cell interface types for the retry timer table.
package rtt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int FUNC_W     = 2;
  localparam int TICK_W     = 16;
  localparam int TRY_W      = 8;
  localparam int OWNER_W    = 32;
  localparam int KSLOT_W    = 4;
  localparam int KIND_W     = 3;
  localparam int SLOT_OUT_W = 4;
  localparam int LIVE_OUT_W = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD     = 2'd0,
    FUNC_KILL    = 2'd1,
    FUNC_ADVANCE = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_FREE = 2'd0,
    ST_LIVE = 2'd1,
    ST_DEAD = 2'd2
  } status_e;

  typedef enum logic [KIND_W-1:0] {
    EV_ADDED     = 3'd0,
    EV_FULL      = 3'd1,
    EV_RETRY     = 3'd2,
    EV_EXHAUSTED = 3'd3,
    EV_DONE      = 3'd4
  } kind_e;

  // Operation broadcast to every cell while an item is being worked on.
  typedef struct packed {
    func_e                op;
    logic [TICK_W-1:0]    ticks;
    logic [TRY_W-1:0]     tries;
    logic [OWNER_W-1:0]   owner;
    logic [TICK_W-1:0]    elapsed;
    logic [SLOT_W-1:0]    kill_idx;
  } cell_cmd_t;

  // Result offered by the cell that holds the token; all zero elsewhere.
  typedef struct packed {
    logic                 emit;
    logic                 last;
    logic                 live;
    logic [KIND_W-1:0]    kind;
    logic [SLOT_W-1:0]    slot;
    logic [OWNER_W-1:0]   owner;
  } cell_ev_t;

  typedef struct packed {
    logic                 tok;
    logic                 held;
    logic [OWNER_W-1:0]   owner;
  } cell_peek_t;

endpackage

// ----- design/rtt_in_if.sv -----
// Input channel of the retry timer table: valid, ready and one command.
interface rtt_in_if;
  logic                         valid;
  logic                         ready;
  logic [rtt_pkg::FUNC_W-1:0]   func;
  logic [rtt_pkg::TICK_W-1:0]   initial_ticks;
  logic [rtt_pkg::TRY_W-1:0]    try_budget;
  logic [rtt_pkg::OWNER_W-1:0]  owner_in;
  logic [rtt_pkg::KSLOT_W-1:0]  kill_slot;
  logic [rtt_pkg::TICK_W-1:0]   elapsed_ticks;

  modport source (
    output valid, func, initial_ticks, try_budget, owner_in, kill_slot, elapsed_ticks,
    input  ready
  );
  modport sink (
    input  valid, func, initial_ticks, try_budget, owner_in, kill_slot, elapsed_ticks,
    output ready
  );
endinterface

// ----- design/rtt_out_if.sv -----
// Output channel of the retry timer table: valid, ready and one event.
interface rtt_out_if;
  logic                            valid;
  logic                            ready;
  logic [rtt_pkg::KIND_W-1:0]      event_kind;
  logic [rtt_pkg::SLOT_OUT_W-1:0]  slot;
  logic [rtt_pkg::OWNER_W-1:0]     owner_out;
  logic [rtt_pkg::LIVE_OUT_W-1:0]  live_count;
  logic                            last;

  modport source (
    output valid, event_kind, slot, owner_out, live_count, last,
    input  ready
  );
  modport sink (
    input  valid, event_kind, slot, owner_out, live_count, last,
    output ready
  );
endinterface

// ----- design/rtt_cell.sv -----
// One timer slot: holds its state and passes the walk token to the next slot.
module rtt_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [rtt_pkg::SLOT_W-1:0] idx_i,
  input  rtt_pkg::cell_cmd_t         cmd_i,
  input  logic                       shift_i,
  input  logic                       step_i,
  input  logic                       kill_i,
  input  logic                       tok_i,
  output logic                       tok_o,
  output rtt_pkg::cell_ev_t          ev_o,
  output rtt_pkg::cell_peek_t        peek_o
);
  import rtt_pkg::*;

  status_e              status_q;
  logic                 tok_q;
  logic [TICK_W-1:0]    ticks_q;
  logic [TRY_W-1:0]     tries_q;
  logic [OWNER_W-1:0]   owner_q;

  logic is_live, is_dead, is_free, expired, stop, update;

  assign is_live = (status_q == ST_LIVE);
  assign is_dead = (status_q == ST_DEAD);
  assign is_free = !is_live && !is_dead;
  assign expired = (ticks_q <= cmd_i.elapsed);

  // An add that lands here ends the walk, so the token goes no further.
  assign stop   = tok_q && (cmd_i.op == FUNC_ADD) && is_free;
  assign tok_o  = tok_q && !stop;
  assign update = step_i && tok_q;

  always_comb begin
    ev_o = '0;
    if (tok_q) begin
      unique case (cmd_i.op)
        FUNC_ADD: begin
          if (is_free) begin
            ev_o.emit  = 1'b1;
            ev_o.last  = 1'b1;
            ev_o.kind  = EV_ADDED;
            ev_o.slot  = idx_i;
            ev_o.owner = cmd_i.owner;
          end
        end
        FUNC_ADVANCE: begin
          if (is_live) begin
            ev_o.live = 1'b1;
            if (expired) begin
              ev_o.emit  = 1'b1;
              ev_o.kind  = (tries_q <= TRY_W'(1)) ? EV_EXHAUSTED : EV_RETRY;
              ev_o.slot  = idx_i;
              ev_o.owner = owner_q;
            end
          end
        end
        default: ev_o = '0;
      endcase
    end
  end

  assign peek_o.tok   = tok_q;
  assign peek_o.held  = !is_free;
  assign peek_o.owner = owner_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_FREE;
      tok_q    <= 1'b0;
    end else begin
      if (shift_i) begin
        tok_q <= tok_i;
      end
      if (update && (cmd_i.op == FUNC_ADD) && is_free) begin
        status_q <= ST_LIVE;
      end else if (update && (cmd_i.op == FUNC_ADVANCE) && is_dead) begin
        status_q <= ST_FREE;
      end else if (kill_i && (cmd_i.kill_idx == idx_i) && is_live) begin
        status_q <= ST_DEAD;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (update && (cmd_i.op == FUNC_ADD) && is_free) begin
      ticks_q <= cmd_i.ticks;
      tries_q <= cmd_i.tries;
      owner_q <= cmd_i.owner;
    end else if (update && (cmd_i.op == FUNC_ADVANCE) && is_live) begin
      if (!expired) begin
        ticks_q <= ticks_q - cmd_i.elapsed;
      end else if (tries_q > TRY_W'(1)) begin
        tries_q <= tries_q - TRY_W'(1);
      end
    end
  end

endmodule

// ----- design/retry_timer_table_top.sv -----
// A kill is registered, then its answer is loaded into the output register once that is
// free. An add walks slots from the lowest up, one slot per cycle, and answers from the
// first free slot, or with a full event after the last. An advance walks every slot, one
// per cycle while each firing slot's event can enter the output register, and ends with
// a done event. One item at a time: the next beat is taken the cycle after the last result
// is loaded. Reset is asynchronous and frees all slots at once.
module retry_timer_table_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  rtt_in_if.sink     in_i,
  rtt_out_if.source  out_o
);
  import rtt_pkg::*;

  logic                 busy_q, tail_q, out_valid_q;
  func_e                op_q;
  logic [CNT_W-1:0]     live_cnt_q;
  logic [TICK_W-1:0]    ticks_q, elapsed_q;
  logic [TRY_W-1:0]     tries_q;
  logic [OWNER_W-1:0]   owner_q;
  logic [KSLOT_W-1:0]   kslot_q;

  logic [KIND_W-1:0]     out_kind_q, out_kind_d;
  logic [SLOT_OUT_W-1:0] out_slot_q, out_slot_d;
  logic [OWNER_W-1:0]    out_owner_q, out_owner_d;
  logic [LIVE_OUT_W-1:0] out_live_q, out_live_d;
  logic                  out_last_q, out_last_d;

  logic                    accept, start, shift, step, kill_go, tail_go, out_free;
  logic                    out_load, tok_any, kill_in_range;
  logic [SLOT_W-1:0]       kill_idx;
  logic [OWNER_W-1:0]      kill_owner;
  logic [TABLE_DEPTH:0]    tok_chain;
  logic [TABLE_DEPTH-1:0]  tok_bits;
  cell_cmd_t               cmd;
  cell_ev_t                ev [TABLE_DEPTH];
  cell_peek_t              peek [TABLE_DEPTH];
  cell_ev_t                ev_any;
  cell_peek_t              peek_sel;

  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && !busy_q;
  assign start      = accept && ((func_e'(in_i.func) == FUNC_ADD) ||
                                 (func_e'(in_i.func) == FUNC_ADVANCE));
  assign out_free   = !out_valid_q || out_o.ready;

  assign kill_in_range = (32'(kslot_q) < TABLE_DEPTH);
  assign kill_idx      = SLOT_W'(kslot_q);

  assign cmd.op       = op_q;
  assign cmd.ticks    = ticks_q;
  assign cmd.tries    = tries_q;
  assign cmd.owner    = owner_q;
  assign cmd.elapsed  = elapsed_q;
  assign cmd.kill_idx = kill_idx;

  assign tok_chain[0] = start;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rtt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (SLOT_W'(i)),
      .cmd_i   (cmd),
      .shift_i (shift),
      .step_i  (step),
      .kill_i  (kill_go && kill_in_range),
      .tok_i   (tok_chain[i]),
      .tok_o   (tok_chain[i+1]),
      .ev_o    (ev[i]),
      .peek_o  (peek[i])
    );
    assign tok_bits[i] = peek[i].tok;
  end

  // Only the token cell drives a non-zero result, so an OR gathers it.
  always_comb begin
    ev_any = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      ev_any = ev_any | ev[i];
    end
  end

  assign tok_any  = |tok_bits;
  assign step     = busy_q && tok_any && (!ev_any.emit || out_free);
  assign shift    = step || start;
  assign kill_go  = busy_q && (op_q == FUNC_KILL) && out_free;
  assign tail_go  = tail_q && out_free;
  assign peek_sel = peek[kill_idx];

  assign kill_owner = (kill_in_range && peek_sel.held) ? peek_sel.owner : '0;

  always_comb begin
    out_load    = 1'b0;
    out_kind_d  = out_kind_q;
    out_slot_d  = out_slot_q;
    out_owner_d = out_owner_q;
    out_live_d  = out_live_q;
    out_last_d  = out_last_q;
    if (step && ev_any.emit) begin
      out_load    = 1'b1;
      out_kind_d  = ev_any.kind;
      out_slot_d  = SLOT_OUT_W'(ev_any.slot);
      out_owner_d = ev_any.owner;
      out_live_d  = '0;
      out_last_d  = ev_any.last;
    end else if (kill_go) begin
      out_load    = 1'b1;
      out_kind_d  = EV_DONE;
      out_slot_d  = kslot_q;
      out_owner_d = kill_owner;
      out_live_d  = '0;
      out_last_d  = 1'b1;
    end else if (tail_go) begin
      out_load    = 1'b1;
      out_kind_d  = (op_q == FUNC_ADD) ? EV_FULL : EV_DONE;
      out_slot_d  = '0;
      out_owner_d = '0;
      out_live_d  = (op_q == FUNC_ADVANCE) ? LIVE_OUT_W'(live_cnt_q) : '0;
      out_last_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      tail_q      <= 1'b0;
      out_valid_q <= 1'b0;
      op_q        <= FUNC_NONE;
      live_cnt_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        busy_q     <= (func_e'(in_i.func) != FUNC_NONE);
        op_q       <= func_e'(in_i.func);
        live_cnt_q <= '0;
      end
      if (step) begin
        live_cnt_q <= live_cnt_q + CNT_W'(ev_any.live);
        if (ev_any.emit && ev_any.last) begin
          busy_q <= 1'b0;
        end
        if (tok_chain[TABLE_DEPTH]) begin
          tail_q <= 1'b1;
        end
      end
      if (kill_go) begin
        busy_q <= 1'b0;
      end
      if (tail_go) begin
        tail_q <= 1'b0;
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ticks_q   <= in_i.initial_ticks;
      tries_q   <= in_i.try_budget;
      owner_q   <= in_i.owner_in;
      kslot_q   <= in_i.kill_slot;
      elapsed_q <= in_i.elapsed_ticks;
    end
    if (out_load) begin
      out_kind_q  <= out_kind_d;
      out_slot_q  <= out_slot_d;
      out_owner_q <= out_owner_d;
      out_live_q  <= out_live_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.event_kind = out_kind_q;
  assign out_o.slot       = out_slot_q;
  assign out_o.owner_out  = out_owner_q;
  assign out_o.live_count = out_live_q;
  assign out_o.last       = out_last_q;

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({tail_q, tok_bits}))
    else $error("more than one walk token in the cell chain");

  a_idle_no_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (!tok_any && !tail_q))
    else $error("walk token present while the table is idle");

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("live count exceeds the table depth");

  a_event_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && ev_any.emit) |=> out_valid_q)
    else $error("cell event was not placed in the output register");
`endif

endmodule

// ----- bench/rtt_event_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the retry timer table: predicts events from command beats and checks output beats.
module rtt_event_checker (
  input  logic clk_i,
  input  logic rst_ni,
  rtt_in_if    in_i,
  rtt_out_if   out_i,
  output int   fail_count_o,
  output int   pending_o
);
  import rtt_pkg::*;

  typedef struct packed {
    kind_e                   kind;
    logic [SLOT_OUT_W-1:0]   slot;
    logic [OWNER_W-1:0]      owner;
    logic [LIVE_OUT_W-1:0]   live;
    logic                    last;
  } table_event_t;

  status_e             slot_state [TABLE_DEPTH];
  logic [TICK_W-1:0]   ticks_left [TABLE_DEPTH];
  logic [TRY_W-1:0]    tries_left [TABLE_DEPTH];
  logic [OWNER_W-1:0]  slot_owner [TABLE_DEPTH];

  table_event_t expected_events [$];
  int mismatches = 0;
  int pending_q  = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending_q;

  function automatic void queue_event(kind_e kind, int slot_idx, logic [OWNER_W-1:0] owner,
                                      int live, logic last);
    table_event_t ev;
    ev.kind  = kind;
    ev.slot  = SLOT_OUT_W'(slot_idx);
    ev.owner = owner;
    ev.live  = LIVE_OUT_W'(live);
    ev.last  = last;
    expected_events.push_back(ev);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    table_event_t        want;
    table_event_t        got;
    logic [KSLOT_W-1:0]  kslot;
    logic [TICK_W-1:0]   elapsed;
    logic [OWNER_W-1:0]  owner;
    int                  live;
    bit                  placed;
    if (!rst_ni) begin
      expected_events.delete();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        slot_state[i] = ST_FREE;
      end
      pending_q <= 0;
    end else begin
      // The output beat always belongs to an earlier command, so it is checked first.
      if (out_i.valid && out_i.ready) begin
        got.kind  = kind_e'(out_i.event_kind);
        got.slot  = out_i.slot;
        got.owner = out_i.owner_out;
        got.live  = out_i.live_count;
        got.last  = out_i.last;
        if (expected_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] event beat with nothing expected: kind=%0d slot=%0d owner=%h",
                     $time, got.kind, got.slot, got.owner);
          end
        end else begin
          want = expected_events.pop_front();
          if (got.kind !== want.kind || got.slot !== want.slot || got.owner !== want.owner ||
              got.live !== want.live || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] event differs: expected kind=%0d slot=%0d owner=%h live=%0d last=%b",
                       $time, want.kind, want.slot, want.owner, want.live, want.last);
              $display("[%0t]                actual   kind=%0d slot=%0d owner=%h live=%0d last=%b",
                       $time, got.kind, got.slot, got.owner, got.live, got.last);
            end
          end
        end
      end

      if (in_i.valid && in_i.ready) begin
        case (func_e'(in_i.func))
          FUNC_ADD: begin
            placed = 1'b0;
            // A dead slot is not reusable until an advance pass has freed it.
            for (int i = 0; i < TABLE_DEPTH && !placed; i++) begin
              if (slot_state[i] != ST_LIVE && slot_state[i] != ST_DEAD) begin
                slot_state[i] = ST_LIVE;
                ticks_left[i] = in_i.initial_ticks;
                tries_left[i] = in_i.try_budget;
                slot_owner[i] = in_i.owner_in;
                queue_event(EV_ADDED, i, in_i.owner_in, 0, 1'b1);
                placed = 1'b1;
              end
            end
            if (!placed) begin
              queue_event(EV_FULL, 0, '0, 0, 1'b1);
            end
          end
          FUNC_KILL: begin
            kslot = in_i.kill_slot;
            owner = '0;
            if (int'(kslot) < TABLE_DEPTH) begin
              if (slot_state[kslot] == ST_LIVE) begin
                slot_state[kslot] = ST_DEAD;
                ticks_left[kslot] = '0;
                tries_left[kslot] = '0;
                owner = slot_owner[kslot];
              end else if (slot_state[kslot] == ST_DEAD) begin
                owner = slot_owner[kslot];
              end
            end
            queue_event(EV_DONE, int'(kslot), owner, 0, 1'b1);
          end
          FUNC_ADVANCE: begin
            elapsed = in_i.elapsed_ticks;
            live    = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
              if (slot_state[i] == ST_LIVE) begin
                // A firing timer keeps its tick count; an exhausted one fires on every pass.
                if (ticks_left[i] <= elapsed) begin
                  if (tries_left[i] <= 8'd1) begin
                    queue_event(EV_EXHAUSTED, i, slot_owner[i], 0, 1'b0);
                  end else begin
                    queue_event(EV_RETRY, i, slot_owner[i], 0, 1'b0);
                    tries_left[i] = tries_left[i] - 8'd1;
                  end
                end else begin
                  ticks_left[i] = ticks_left[i] - elapsed;
                end
                live++;
              end else if (slot_state[i] == ST_DEAD) begin
                slot_state[i] = ST_FREE;
              end
            end
            queue_event(EV_DONE, 0, '0, live, 1'b1);
          end
          default: ;
        endcase
      end
      pending_q <= expected_events.size();
    end
  end

endmodule

// ----- bench/tb_retry_timer_table_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the retry timer table: clock, reset, command stimulus, output stalls, verdict.
module tb_retry_timer_table_top;
  import rtt_pkg::*;

  localparam int ITEM_TARGET      = 410;
  localparam int HOLD_AFTER_BEATS = 80;
  localparam int HOLD_CYCLES      = 400;
  localparam int IDLE_LIMIT       = 4000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  int   send_calm   = 0;

  rtt_in_if  in_if ();
  rtt_out_if out_if ();

  retry_timer_table_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  rtt_event_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_i        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mostly random waits, with occasional runs of back-to-back beats.
  task automatic draw_wait(inout int calm_left, output int cycles);
    if (calm_left > 0) begin
      calm_left--;
      cycles = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      calm_left = $urandom_range(8, 30);
      cycles = 0;
    end else begin
      cycles = $urandom_range(0, 18);
    end
  endtask

  task automatic send_cmd(input func_e op, input logic [TICK_W-1:0] ticks,
                          input logic [TRY_W-1:0] tries, input logic [OWNER_W-1:0] owner,
                          input logic [KSLOT_W-1:0] kslot, input logic [TICK_W-1:0] elapsed);
    int gap;
    draw_wait(send_calm, gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.func          <= op;
    in_if.initial_ticks <= ticks;
    in_if.try_budget    <= tries;
    in_if.owner_in      <= owner;
    in_if.kill_slot     <= kslot;
    in_if.elapsed_ticks <= elapsed;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Holds the command channel idle until every predicted event has been seen.
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : receiver
    int calm;
    int stall;
    int beats;
    calm  = 0;
    beats = 0;
    out_if.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      // One long hold-off fills the block and backs up the command channel.
      if (beats == HOLD_AFTER_BEATS) begin
        stall = HOLD_CYCLES;
      end else begin
        draw_wait(calm, stall);
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      beats++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("retry_timer_table_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int    sent;
    int    pick;
    func_e op;
    in_if.valid         <= 1'b0;
    in_if.func          <= FUNC_ADD;
    in_if.initial_ticks <= '0;
    in_if.try_budget    <= '0;
    in_if.owner_in      <= '0;
    in_if.kill_slot     <= '0;
    in_if.elapsed_ticks <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: a pass with nothing live and a kill of a free slot at each end.
    send_cmd(FUNC_ADVANCE, 16'd0, 8'd0, 32'd0, 4'd0, 16'd0);
    send_cmd(FUNC_KILL, 16'd0, 8'd0, 32'd0, 4'd0, 16'd0);
    send_cmd(FUNC_KILL, 16'd0, 8'd0, 32'd0, 4'd15, 16'd0);
    // Zero ticks with a zero try budget, then the widest values.
    send_cmd(FUNC_ADD, 16'd0, 8'd0, 32'd0, 4'd0, 16'd0);
    send_cmd(FUNC_ADD, 16'hffff, 8'hff, 32'hffff_ffff, 4'd0, 16'd0);
    send_cmd(FUNC_ADD, 16'd1, 8'd1, 32'ha5a5_a5a5, 4'd0, 16'd0);
    send_cmd(FUNC_ADD, 16'd3, 8'd2, 32'h5a5a_5a5a, 4'd0, 16'd0);
    send_cmd(FUNC_ADVANCE, 16'd0, 8'd0, 32'd0, 4'd0, 16'd0);
    send_cmd(FUNC_ADVANCE, 16'd0, 8'd0, 32'd0, 4'd0, 16'd1);
    send_cmd(FUNC_ADVANCE, 16'd0, 8'd0, 32'd0, 4'd0, 16'd2);
    send_cmd(FUNC_ADVANCE, 16'd0, 8'd0, 32'd0, 4'd0, 16'hffff);
    // Kill a live slot, then the same slot again while it is dead.
    send_cmd(FUNC_KILL, 16'd0, 8'd0, 32'd0, 4'd1, 16'd0);
    send_cmd(FUNC_KILL, 16'd0, 8'd0, 32'd0, 4'd1, 16'd0);
    send_cmd(FUNC_ADD, 16'd7, 8'd3, 32'h1234_5678, 4'd0, 16'd0);
    send_cmd(FUNC_NONE, 16'hffff, 8'hff, 32'hffff_ffff, 4'd15, 16'hffff);
    send_cmd(FUNC_ADVANCE, 16'd0, 8'd0, 32'd0, 4'd0, 16'd5);
    send_cmd(FUNC_ADD, 16'd20, 8'd4, 32'h8765_4321, 4'd0, 16'd0);
    // Fill every slot and go one past to see the table full.
    for (int i = 0; i < 12; i++) begin
      send_cmd(FUNC_ADD, 16'($urandom_range(0, 40)), 8'($urandom_range(0, 3)), $urandom,
               4'd0, 16'd0);
    end
    drain();

    sent = 0;
    while (sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        op = FUNC_ADD;
      end else if (pick < 60) begin
        op = FUNC_KILL;
      end else if (pick < 95) begin
        op = FUNC_ADVANCE;
      end else begin
        op = FUNC_NONE;
      end
      send_cmd(op,
               ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(0, 40)),
               ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 4)),
               $urandom,
               4'($urandom_range(0, 15)),
               ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(0, 30)));
      if (op != FUNC_NONE) begin
        sent++;
        if (sent == ITEM_TARGET / 2) begin
          drain();
        end
      end
    end
    drain();
    repeat (TABLE_DEPTH + 4) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("retry_timer_table_top: match");
    end else begin
      $display("retry_timer_table_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/rtt_pkg.sv
design/rtt_in_if.sv
design/rtt_out_if.sv
design/rtt_cell.sv
design/retry_timer_table_top.sv
bench/rtt_event_checker.sv
bench/tb_retry_timer_table_top.sv
